// ===== rtl/clug_pkg.sv =====
// Shared constants, types and command struct of the combined LCG generator.
package clug_pkg;

   localparam int unsigned SEED_W = 31;

   // Index of each configuration register.
   localparam logic CSR_START_FIRST  = 1'b0;
   localparam logic CSR_START_SECOND = 1'b1;

   // Generator constants; each modulus is a*q + r.
   localparam longint unsigned A1 = 64'd40014;
   localparam longint unsigned Q1 = 64'd53668;
   localparam longint unsigned R1 = 64'd12211;
   localparam longint unsigned M1 = A1 * Q1 + R1;
   localparam longint unsigned A2 = 64'd40692;
   localparam longint unsigned Q2 = 64'd52774;
   localparam longint unsigned R2 = 64'd3791;
   localparam longint unsigned M2 = A2 * Q2 + R2;
   localparam longint unsigned WRAP = 64'd2147483562;

   // Quotient by q through a reciprocal: floor(v * RECIP >> RECIP_SHIFT) is low by at most one.
   localparam int unsigned RECIP_SHIFT = 47;
   localparam longint unsigned RECIP1 = (64'd1 << RECIP_SHIFT) / Q1;
   localparam longint unsigned RECIP2 = (64'd1 << RECIP_SHIFT) / Q2;

   typedef struct packed {
      logic [15:0] mult;
      logic [15:0] divisor;
      logic [31:0] modulus;
      logic [31:0] recip;
   } lane_const_type;

   localparam lane_const_type LANE_FIRST = '{
      mult:    16'(A1),
      divisor: 16'(Q1),
      modulus: 32'(M1),
      recip:   32'(RECIP1)
   };
   localparam lane_const_type LANE_SECOND = '{
      mult:    16'(A2),
      divisor: 16'(Q2),
      modulus: 32'(M2),
      recip:   32'(RECIP2)
   };

   // Commands from the controller to the datapath, at most one step per cycle.
   typedef struct packed {
      logic load;
      logic mul_recip;
      logic mul_kq;
      logic mul_av;
      logic mul_km;
      logic sub;
      logic fix;
      logic out;
   } cmd_type;

endpackage

// ===== rtl/clug_lane.sv =====
// One Schrage lane: seed register and a multiplier shared over four steps.
module clug_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  clug_pkg::cmd_type        cmd,
   input  clug_pkg::lane_const_type lc,
   input  logic                     reload,
   input  logic [30:0]              start_seed,
   output logic [30:0]              seed
);
   import clug_pkg::*;

   logic [30:0] seed_ff, seed_in;
   logic [30:0] v_ff;
   logic [63:0] prod_ff, prod_in;
   logic [15:0] kest_ff;
   logic [15:0] k_ff;
   logic [33:0] av_ff;
   logic [33:0] t_ff;
   logic [31:0] mul_a, mul_b;
   logic [31:0] kq_plus_q;
   logic        bump;
   logic [33:0] t_fixed;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.mul_recip) begin
         mul_a = {1'b0, v_ff};
         mul_b = lc.recip;
      end else if (cmd.mul_kq) begin
         mul_a = {16'b0, prod_ff[RECIP_SHIFT +: 16]};
         mul_b = {16'b0, lc.divisor};
      end else if (cmd.mul_av) begin
         mul_a = {1'b0, v_ff};
         mul_b = {16'b0, lc.mult};
      end else if (cmd.mul_km) begin
         mul_a = {16'b0, k_ff};
         mul_b = lc.modulus;
      end
   end

   assign prod_in   = 64'(mul_a) * 64'(mul_b);
   // Quotient estimate is one low when the remainder reaches q.
   assign kq_plus_q = prod_ff[31:0] + {16'b0, lc.divisor};
   assign bump      = ({1'b0, v_ff} >= kq_plus_q);
   assign t_fixed   = t_ff + {2'b0, lc.modulus};
   assign seed_in   = t_ff[33] ? t_fixed[30:0] : t_ff[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 31'd1;
      end else if (cmd.fix) begin
         seed_ff <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff <= reload ? start_seed : seed_ff;
      end
      if (cmd.mul_recip || cmd.mul_kq || cmd.mul_av || cmd.mul_km) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_kq) begin
         kest_ff <= prod_ff[RECIP_SHIFT +: 16];
      end
      if (cmd.mul_av) begin
         k_ff <= kest_ff + {15'b0, bump};
      end
      if (cmd.mul_km) begin
         av_ff <= prod_ff[33:0];
      end
      if (cmd.sub) begin
         t_ff <= av_ff - prod_ff[33:0];
      end
   end

   assign seed = seed_ff;

endmodule

// ===== rtl/clug_datapath.sv =====
// Datapath: start-seed registers, both lanes and the combining output register.
module clug_datapath (
   input  logic              clock,
   input  logic              reset,
   input  clug_pkg::cmd_type cmd,
   input  logic              reload,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [30:0]       csr_wdata,
   output logic [30:0]       sample
);
   import clug_pkg::*;

   logic [30:0] start_first_ff, start_second_ff;
   logic [30:0] first_seed, second_seed;
   logic [30:0] sample_ff, sample_in;
   logic [31:0] diff;
   logic [31:0] wrapped;
   logic        nonpos;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_first_ff  <= 31'd1;
         start_second_ff <= 31'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_FIRST:  start_first_ff  <= csr_wdata;
            CSR_START_SECOND: start_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   clug_lane u_lane_first (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .lc         (LANE_FIRST),
      .reload     (reload),
      .start_seed (start_first_ff),
      .seed       (first_seed)
   );

   clug_lane u_lane_second (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .lc         (LANE_SECOND),
      .reload     (reload),
      .start_seed (start_second_ff),
      .seed       (second_seed)
   );

   // Wrap a difference below one into range.
   assign diff      = {1'b0, first_seed} - {1'b0, second_seed};
   assign wrapped   = diff + 32'(WRAP);
   assign nonpos    = diff[31] || (diff == '0);
   assign sample_in = nonpos ? wrapped[30:0] : diff[30:0];

   always_ff @(posedge clock) begin
      if (cmd.out) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

// ===== rtl/clug_ctrl.sv =====
// Controller: step sequencer and handshake of both stream channels.
module clug_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output clug_pkg::cmd_type cmd
);
   import clug_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RECIP = 8'b0000_0010,
      ST_KQ    = 8'b0000_0100,
      ST_AV    = 8'b0000_1000,
      ST_KM    = 8'b0001_0000,
      ST_SUB   = 8'b0010_0000,
      ST_FIX   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_RECIP;
         ST_RECIP: state_in = ST_KQ;
         ST_KQ:    state_in = ST_AV;
         ST_AV:    state_in = ST_KM;
         ST_KM:    state_in = ST_SUB;
         ST_SUB:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_OUT;
         ST_OUT:   if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_tvalid;
      cmd.mul_recip = (state_ff == ST_RECIP);
      cmd.mul_kq    = (state_ff == ST_KQ);
      cmd.mul_av    = (state_ff == ST_AV);
      cmd.mul_km    = (state_ff == ST_KM);
      cmd.sub       = (state_ff == ST_SUB);
      cmd.fix       = (state_ff == ST_FIX);
      cmd.out       = (state_ff == ST_OUT) && slot_free;
   end

   assign rsp_valid_in = cmd.out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_RECIP)
      else $error("accepted beat did not start the multiply sequence");

   a_fix_then_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIX |=> state_ff == ST_OUT)
      else $error("seed update not followed by output step");

   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside the output step");
`endif

endmodule

// ===== rtl/combined_lcg_uniform_generator_top.sv =====
// Top level of the combined two-stream LCG uniform generator.
//
// Each request beat advances two multiplicative congruential seeds, the first by
// 40014 mod 2147483563 and the second by 40692 mod 2147483399, and returns one
// result beat holding their difference wrapped into 1..2147483562; the uniform
// fraction is sample / 2^31. With reload set, the configured start seeds are
// copied into the state before the step. One beat is worked at a time: once a
// request is accepted, the sequencer runs through the four products each lane
// forms on its single multiplier (quotient estimate by reciprocal, quotient
// check, a*seed, quotient*modulus), then a subtract, a modulus fix-up and the
// output step, and takes the next request only when back at idle. The result
// sits in an output register, so a request can be accepted while the previous
// result still waits; a stalled output holds the sequencer at its output step.
// Start-seed registers are written through the csr port; the user must write
// them only while the block is idle, as the block itself does not enforce it.
module combined_lcg_uniform_generator_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] reload, [7:1] zero fill
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] sample, [31] zero fill
   // configuration write port
   input  logic        csr_we,
   input  logic        csr_index,   // 0 start_first_seed, 1 start_second_seed
   input  logic [30:0] csr_wdata
);
   import clug_pkg::*;

   cmd_type     cmd;
   logic [30:0] sample;

   // Sequence the steps and own both handshakes.
   clug_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Hold the seeds, run the Schrage arithmetic and register the sample.
   clug_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .reload    (req_tdata[0]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample    (sample)
   );

   assign rsp_tdata = {1'b0, sample};

endmodule

// ===== tb/sv/combined_lcg_uniform_generator_top_test.sv =====
// Self-checking testbench for the combined two-stream LCG uniform generator top level.
module combined_lcg_uniform_generator_top_test;
   import clug_pkg::*;

   localparam int CLOCK_HALF      = 2;
   localparam int RESET_CYCLES    = 11;
   // Wait after the last result comes back, with margin, so the block is idle.
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASES          = 8;
   localparam int PHASE_BEATS     = 220;
   localparam int DIRECTED_ROWS   = 18;
   // Watchdog limit on the whole run, in clock cycles.
   localparam int LIMIT_CYCLES    = 400000;
   localparam logic [30:0] SEED_ALL_ONES = 31'h7FFF_FFFF;

   // One directed row: optional start-seed write before the beat, the reload
   // flag, and a typed-in sample where it is obvious from the arithmetic.
   typedef struct packed {
      logic        write_seeds;
      logic [30:0] first_start;
      logic [30:0] second_start;
      logic        reload;
      logic        known;
      logic [30:0] sample;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [0] reload, [7:1] zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [30:0] sample, [31] zero fill
   logic        csr_we     = 1'b0;
   logic        csr_index  = CSR_START_FIRST;
   logic [30:0] csr_wdata  = 31'd0;

   always #(CLOCK_HALF) clock = ~clock;

   combined_lcg_uniform_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the generator: start-seed registers and the two live seeds.
   logic [30:0] start_first_seed  = 31'd1;
   logic [30:0] start_second_seed = 31'd1;
   logic [30:0] first_seed        = 31'd1;
   logic [30:0] second_seed       = 31'd1;

   logic [30:0]  pending_samples [$];
   int           mismatches    = 0;
   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   logic         hold_off_req  = 1'b0;
   stim_row_type directed_rows [DIRECTED_ROWS];

   // Multiply a seed by a modulo m through Schrage's split m = a*q + r.
   // Seeds at or above m go through the same steps, as the hardware does.
   function automatic logic [30:0] schrage_mulmod(logic [30:0] seed, longint mult,
                                                  longint divisor, longint rem,
                                                  longint modulus);
      longint v, k, t;
      v = seed;
      k = v / divisor;
      t = mult * (v - k * divisor) - k * rem;
      if (t < 0)
         t += modulus;
      return t[30:0];
   endfunction

   // Advance both streams by one step and form the wrapped difference.
   function automatic logic [30:0] advance_uniform(logic reload);
      longint a, b, diff;
      if (reload) begin
         first_seed  = start_first_seed;
         second_seed = start_second_seed;
      end
      first_seed  = schrage_mulmod(first_seed, longint'(A1), longint'(Q1),
                                   longint'(R1), longint'(M1));
      second_seed = schrage_mulmod(second_seed, longint'(A2), longint'(Q2),
                                   longint'(R2), longint'(M2));
      a    = first_seed;
      b    = second_seed;
      diff = a - b;
      if (diff < 1)
         diff += longint'(WRAP);
      return diff[30:0];
   endfunction

   // Bias start seeds toward the edges: zero, one, modulus - 1, the modulus
   // itself and all ones, with plain random values the rest of the time.
   function automatic logic [30:0] pick_seed(longint modulus);
      case ($urandom_range(7))
         0: return 31'd0;
         1: return 31'd1;
         2: return 31'(modulus - 1);
         3: return 31'(modulus);
         4: return SEED_ALL_ONES;
         default: return 31'($urandom());
      endcase
   endfunction

   // Write both start-seed registers back to back, first then second; call only while idle.
   task automatic write_start_seeds(logic [30:0] first_val, logic [30:0] second_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_FIRST;
      csr_wdata <= first_val;
      @(posedge clock);
      start_first_seed = first_val;
      csr_index <= CSR_START_SECOND;
      csr_wdata <= second_val;
      @(posedge clock);
      start_second_seed = second_val;
      csr_we <= 1'b0;
   endtask

   // Drop valid, wait until every expected sample has come back, then let the
   // sequencer settle so the block is idle for a register write.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one request beat, hold it until accepted, record the expected sample,
   // then idle the sender at random. Valid stays high when no gap is drawn, so
   // the next beat follows without a bubble.
   task automatic send_beat(logic reload, logic known, logic [30:0] typed_sample);
      logic [30:0] predicted;
      int          gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, reload};
      do
         @(posedge clock);
      while (!req_tready);
      predicted = advance_uniform(reload);
      pending_samples.push_back(known ? typed_sample : predicted);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result side: check each accepted beat against the oldest expectation, then
   // pick the next ready value (long hold-off when asked, else random stalls).
   initial begin
      logic [30:0] expected;
      int          hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_samples.size() == 0) begin
               mismatches++;
               $display("%0t: sample with none expected, got %0d", $time,
                        rsp_tdata[30:0]);
            end else begin
               expected = pending_samples.pop_front();
               if (rsp_tdata[30:0] !== expected) begin
                  mismatches++;
                  $display("%0t: sample expected %0d, got %0d", $time, expected,
                           rsp_tdata[30:0]);
               end
            end
         end
         if (hold_off_req) begin
            hold_off_req <= 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (reset)
            rsp_tready <= 1'b0;
         else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Stimulus: directed table first, then random phases with fresh start seeds.
   initial begin
      stim_row_type row;
      int           phase_mode;
      // Typed samples: seeds 1,1 give 40014 - 40692 wrapped; modulus - 1 seeds
      // give m - a on each side; zero seeds stay zero; a lone zero leaves the
      // other stream's product (wrapped when it is the first that is zero).
      directed_rows = '{
         '{1'b0, 31'd0,          31'd0,          1'b0, 1'b1, 31'd2147482884},
         '{1'b0, 31'd0,          31'd0,          1'b0, 1'b0, 31'd0},
         '{1'b0, 31'd0,          31'd0,          1'b1, 1'b1, 31'd2147482884},
         '{1'b1, 31'd2147483562, 31'd2147483398, 1'b1, 1'b1, 31'd842},
         '{1'b0, 31'd0,          31'd0,          1'b0, 1'b0, 31'd0},
         '{1'b1, 31'd0,          31'd0,          1'b1, 1'b1, 31'd2147483562},
         '{1'b0, 31'd0,          31'd0,          1'b0, 1'b1, 31'd2147483562},
         '{1'b1, 31'd1,          31'd0,          1'b1, 1'b1, 31'd40014},
         '{1'b0, 31'd0,          31'd0,          1'b0, 1'b0, 31'd0},
         '{1'b1, 31'd0,          31'd1,          1'b1, 1'b1, 31'd2147442870},
         '{1'b0, 31'd0,          31'd0,          1'b0, 1'b0, 31'd0},
         '{1'b1, SEED_ALL_ONES,  SEED_ALL_ONES,  1'b1, 1'b0, 31'd0},
         '{1'b0, 31'd0,          31'd0,          1'b0, 1'b0, 31'd0},
         '{1'b1, SEED_ALL_ONES,  31'd1,          1'b1, 1'b0, 31'd0},
         '{1'b1, 31'd2147483563, 31'd2147483399, 1'b1, 1'b0, 31'd0},
         '{1'b1, 31'd12345,      31'd67890,      1'b1, 1'b0, 31'd0},
         '{1'b0, 31'd0,          31'd0,          1'b0, 1'b0, 31'd0},
         '{1'b1, 31'd1,          31'd1,          1'b0, 1'b0, 31'd0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part runs with no idling on either side.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.write_seeds) begin
            drain();
            write_start_seeds(row.first_start, row.second_start);
         end
         send_beat(row.reload, row.known, row.sample);
      end
      drain();

      // Random phases cycle through: no idling, sender idle, receiver
      // stalling, and both idling at about a third of the cycles.
      for (int p = 0; p < PHASES; p++) begin
         phase_mode = p % 4;
         send_idle_pct = (phase_mode == 1) ? 69 : (phase_mode == 3) ? 34 : 0;
         stall_pct     = (phase_mode == 2) ? 69 : (phase_mode == 3) ? 34 : 0;
         write_start_seeds(pick_seed(longint'(M1)), pick_seed(longint'(M2)));
         // Start each phase from the fresh start seeds, then mostly advance.
         send_beat(1'b1, 1'b0, 31'd0);
         for (int n = 1; n < PHASE_BEATS; n++) begin
            // Stall the result side for a long stretch while requests keep
            // coming, so the output register fills and backs up the input.
            if (p == 0 && n == 40)
               hold_off_req <= 1'b1;
            // Pause the sender until the block has emptied.
            if (p == 1 && n == 100)
               drain();
            send_beat($urandom_range(19) == 0, 1'b0, 31'd0);
         end
         drain();
      end

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(2 * CLOCK_HALF * LIMIT_CYCLES);
      $display("Mismatches found");
      $finish;
   end

endmodule
